>>> hw/rtl/i2cm_pkg.sv
// ============================================================================
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ============================================================================
`default_nettype none

package i2cm_pkg;

   // Command codes as they arrive on the request channel.
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // Register indexes (byte address bits [3:2]).
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam logic [1:0]  REG_SHORT   = 2'd0;
   localparam logic [1:0]  REG_LONG    = 2'd1;
   localparam logic [1:0]  REG_TIMEOUT = 2'd2;

   localparam int unsigned SHORT_W   = 10;
   localparam int unsigned LONG_W    = 10;
   localparam int unsigned TIMEOUT_W = 16;

   localparam logic [SHORT_W-1:0]   SHORT_RESET   = 10'd60;
   localparam logic [LONG_W-1:0]    LONG_RESET    = 10'd120;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10000;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [3:0] BITS_AFTER_FIRST = 4'd7;

   // Queue between the classifier and the sequencer.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] write_byte;
      logic       send_nack;
      logic       scl_in;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic [SHORT_W-1:0]   short_delay;
      logic [LONG_W-1:0]    long_delay;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } cfg_type;

   // Packed from the top down, so scl_release lands in bit 0.
   typedef struct packed {
      logic [7:0] read_byte;
      logic       nack_status;
      logic       done_res;
      logic       busy_res;
      logic       sda_release;
      logic       scl_release;
   } result_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_CHECK, PH_ST_PLO, PH_ST_PHI, PH_ST_A, PH_ST_B,
      PH_SP_A, PH_SP_B, PH_SP_WAIT, PH_SP_C, PH_SP_D,
      PH_W1_RISE, PH_W1_WAIT, PH_W1_HOLD, PH_BO_LOW, PH_BO_HIGH,
      PH_AK_LOW, PH_AK_WAIT, PH_AK_HOLD, PH_RB_LOW, PH_RB_WAIT, PH_RB_HIGH
   } phase_type;

endpackage

`default_nettype wire

>>> hw/rtl/i2cm_csr.sv
// ============================================================================
// i2cm_csr
// Timing registers behind the APB-style configuration port.
// ============================================================================
`default_nettype none

module i2cm_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [i2cm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [31:0]                       csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output i2cm_pkg::cfg_type                cfg
);

   i2cm_pkg::cfg_type cfg_ff;
   i2cm_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            i2cm_pkg::REG_SHORT:   cfg_in.short_delay   = csr_pwdata[i2cm_pkg::SHORT_W-1:0];
            i2cm_pkg::REG_LONG:    cfg_in.long_delay    = csr_pwdata[i2cm_pkg::LONG_W-1:0];
            i2cm_pkg::REG_TIMEOUT: cfg_in.timeout_ticks = csr_pwdata[i2cm_pkg::TIMEOUT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         i2cm_pkg::REG_SHORT:
            csr_prdata = {{(32-i2cm_pkg::SHORT_W){1'b0}}, cfg_ff.short_delay};
         i2cm_pkg::REG_LONG:
            csr_prdata = {{(32-i2cm_pkg::LONG_W){1'b0}}, cfg_ff.long_delay};
         i2cm_pkg::REG_TIMEOUT:
            csr_prdata = {{(32-i2cm_pkg::TIMEOUT_W){1'b0}}, cfg_ff.timeout_ticks};
         default:
            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_delay   <= i2cm_pkg::SHORT_RESET;
         cfg_ff.long_delay    <= i2cm_pkg::LONG_RESET;
         cfg_ff.timeout_ticks <= i2cm_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/i2cm_front.sv
// ============================================================================
// i2cm_front
// Request intake: decodes the command code and unpacks the line samples.
// ============================================================================
`default_nettype none

module i2cm_front (
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire [2:0]           req_tuser,
   input  wire [15:0]          req_tdata,
   input  wire                 queue_full,
   output logic                push,
   output i2cm_pkg::tick_type  tick
);

   i2cm_pkg::kind_type kind;

   // Codes above read byte mean nothing and become an empty tick.
   always_comb begin
      unique case (req_tuser)
         i2cm_pkg::CMD_START: kind = i2cm_pkg::KIND_START;
         i2cm_pkg::CMD_STOP:  kind = i2cm_pkg::KIND_STOP;
         i2cm_pkg::CMD_WRITE: kind = i2cm_pkg::KIND_WRITE;
         i2cm_pkg::CMD_READ:  kind = i2cm_pkg::KIND_READ;
         default:             kind = i2cm_pkg::KIND_NONE;
      endcase
   end

   assign req_tready      = ~queue_full;
   assign push            = req_tvalid & ~queue_full;
   assign tick.kind       = kind;
   assign tick.write_byte = req_tdata[7:0];
   assign tick.send_nack  = req_tdata[8];
   assign tick.scl_in     = req_tdata[9];
   assign tick.sda_in     = req_tdata[10];

endmodule

`default_nettype wire

>>> hw/rtl/i2cm_queue.sv
// ============================================================================
// i2cm_queue
// Short first-in first-out queue of decoded ticks.
// ============================================================================
`default_nettype none

module i2cm_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  i2cm_pkg::tick_type  push_tick,
   input  wire                 pop,
   output i2cm_pkg::tick_type  head_tick,
   output logic                empty,
   output logic                full
);

   i2cm_pkg::tick_type                  slot_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == i2cm_pkg::QUEUE_CNT_W'(i2cm_pkg::QUEUE_DEPTH));
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign head_tick = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_tick;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/i2cm_seq.sv
// ============================================================================
// i2cm_seq
// Pin-level phase sequencer, one tick per step, with a registered result.
// ============================================================================
`default_nettype none

module i2cm_seq #(
   parameter int unsigned TIMEOUT_WIDTH = 16,
   parameter int unsigned DELAY_WIDTH   = 10
) (
   input  wire                 clock,
   input  wire                 reset,
   input  i2cm_pkg::cfg_type   cfg,
   input  i2cm_pkg::tick_type  tick,
   input  wire                 tick_valid,
   output logic                tick_pop,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [15:0]         rsp_tdata
);

   localparam logic [DELAY_WIDTH-1:0] DLY_ONE = DELAY_WIDTH'(1);

   i2cm_pkg::phase_type       phase_ff, phase_in;
   i2cm_pkg::kind_type        held_ff, held_in;
   logic [DELAY_WIDTH-1:0]    delay_ff, delay_in;
   logic [TIMEOUT_WIDTH-1:0]  timeout_ff, timeout_in;
   logic [3:0]                bits_ff, bits_in;
   logic [7:0]                shift_ff, shift_in;
   logic                      nack_ff, nack_in;
   logic                      ack_ff, ack_in;
   logic                      scl_out_ff, scl_out_in;
   logic                      sda_out_ff, sda_out_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::result_type      result_ff, result_in;

   logic                      step;
   logic                      dly_over;
   logic                      tmo_zero;
   logic                      done;
   logic [3:0]                bits_dec;
   logic [DELAY_WIDTH-1:0]    short_load;
   logic [DELAY_WIDTH-1:0]    long_load;
   logic [TIMEOUT_WIDTH-1:0]  timeout_load;
   logic [TIMEOUT_WIDTH-1:0]  timeout_tick;

   // A tick is taken whenever the result register is free or being drained.
   assign step     = tick_valid & (~rsp_valid_ff | rsp_tready);
   assign tick_pop = step;

   assign short_load   = DELAY_WIDTH'(cfg.short_delay);
   assign long_load    = DELAY_WIDTH'(cfg.long_delay);
   assign timeout_load = TIMEOUT_WIDTH'(cfg.timeout_ticks);
   assign dly_over     = (delay_ff <= DLY_ONE);
   assign tmo_zero     = (timeout_ff == '0);
   assign timeout_tick = tmo_zero ? timeout_ff : timeout_ff - 1'b1;
   assign bits_dec     = (bits_ff != 4'd0) ? bits_ff - 1'b1 : bits_ff;

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      delay_in   = dly_over ? delay_ff : delay_ff - 1'b1;
      timeout_in = timeout_ff;
      bits_in    = bits_ff;
      shift_in   = shift_ff;
      nack_in    = nack_ff;
      ack_in     = ack_ff;
      scl_out_in = scl_out_ff;
      sda_out_in = sda_out_ff;
      done       = 1'b0;

      unique case (phase_ff)
         i2cm_pkg::PH_IDLE: begin
            if (tick.kind != i2cm_pkg::KIND_NONE) begin
               held_in = tick.kind;
               nack_in = 1'b0;
            end
            case (tick.kind)
               i2cm_pkg::KIND_START: begin
                  scl_out_in = 1'b1;
                  sda_out_in = 1'b1;
                  timeout_in = timeout_load;
                  phase_in   = i2cm_pkg::PH_ST_CHECK;
               end
               i2cm_pkg::KIND_STOP: begin
                  delay_in = short_load;
                  phase_in = i2cm_pkg::PH_SP_A;
               end
               i2cm_pkg::KIND_WRITE: begin
                  shift_in   = tick.write_byte;
                  bits_in    = i2cm_pkg::BITS_PER_BYTE;
                  scl_out_in = 1'b0;
                  sda_out_in = tick.write_byte[7];
                  phase_in   = i2cm_pkg::PH_W1_RISE;
               end
               i2cm_pkg::KIND_READ: begin
                  shift_in   = 8'd0;
                  bits_in    = i2cm_pkg::BITS_PER_BYTE;
                  ack_in     = tick.send_nack;
                  scl_out_in = 1'b0;
                  sda_out_in = 1'b1;
                  delay_in   = short_load;
                  phase_in   = i2cm_pkg::PH_RB_LOW;
               end
               default: begin
                  phase_in = i2cm_pkg::PH_IDLE;
               end
            endcase
         end
         i2cm_pkg::PH_ST_CHECK: begin
            if (tmo_zero) begin
               nack_in = 1'b1;
               done    = 1'b1;
            end else if (tick.scl_in && tick.sda_in) begin
               delay_in = short_load;
               phase_in = i2cm_pkg::PH_ST_A;
            end else begin
               // SDA held low by a slave: clock it out with a recovery pulse.
               if (!tick.sda_in) begin
                  scl_out_in = 1'b0;
                  delay_in   = short_load;
                  phase_in   = i2cm_pkg::PH_ST_PLO;
               end
               timeout_in = timeout_tick;
            end
         end
         i2cm_pkg::PH_ST_PLO: begin
            timeout_in = timeout_tick;
            if (dly_over) begin
               scl_out_in = 1'b1;
               delay_in   = short_load;
               phase_in   = i2cm_pkg::PH_ST_PHI;
            end
         end
         i2cm_pkg::PH_ST_PHI: begin
            timeout_in = timeout_tick;
            if (dly_over) begin
               phase_in = i2cm_pkg::PH_ST_CHECK;
            end
         end
         i2cm_pkg::PH_ST_A: begin
            if (dly_over) begin
               sda_out_in = 1'b0;
               delay_in   = short_load;
               phase_in   = i2cm_pkg::PH_ST_B;
            end
         end
         i2cm_pkg::PH_ST_B: begin
            if (dly_over) begin
               scl_out_in = 1'b0;
               nack_in    = 1'b0;
               done       = 1'b1;
            end
         end
         i2cm_pkg::PH_SP_A: begin
            if (dly_over) begin
               scl_out_in = 1'b0;
               sda_out_in = 1'b0;
               delay_in   = short_load;
               phase_in   = i2cm_pkg::PH_SP_B;
            end
         end
         i2cm_pkg::PH_SP_B: begin
            if (dly_over) begin
               scl_out_in = 1'b1;
               timeout_in = timeout_load;
               phase_in   = i2cm_pkg::PH_SP_WAIT;
            end
         end
         i2cm_pkg::PH_SP_WAIT: begin
            if (tick.scl_in || tmo_zero) begin
               delay_in = short_load;
               phase_in = i2cm_pkg::PH_SP_C;
            end else begin
               timeout_in = timeout_tick;
            end
         end
         i2cm_pkg::PH_SP_C: begin
            if (dly_over) begin
               sda_out_in = 1'b1;
               scl_out_in = 1'b1;
               delay_in   = long_load;
               phase_in   = i2cm_pkg::PH_SP_D;
            end
         end
         i2cm_pkg::PH_SP_D: begin
            if (dly_over) begin
               nack_in = 1'b0;
               done    = 1'b1;
            end
         end
         i2cm_pkg::PH_W1_RISE: begin
            scl_out_in = 1'b1;
            timeout_in = timeout_load;
            phase_in   = i2cm_pkg::PH_W1_WAIT;
         end
         i2cm_pkg::PH_W1_WAIT: begin
            if (tick.scl_in) begin
               nack_in  = 1'b0;
               delay_in = long_load;
               phase_in = i2cm_pkg::PH_W1_HOLD;
            end else if (tmo_zero) begin
               nack_in  = 1'b1;
               delay_in = long_load;
               phase_in = i2cm_pkg::PH_W1_HOLD;
            end else begin
               timeout_in = timeout_tick;
            end
         end
         i2cm_pkg::PH_W1_HOLD: begin
            if (dly_over) begin
               scl_out_in = 1'b0;
               if (nack_ff) begin
                  done = 1'b1;
               end else begin
                  bits_in    = i2cm_pkg::BITS_AFTER_FIRST;
                  shift_in   = {shift_ff[6:0], 1'b0};
                  sda_out_in = shift_ff[6];
                  delay_in   = short_load;
                  phase_in   = i2cm_pkg::PH_BO_LOW;
               end
            end
         end
         i2cm_pkg::PH_BO_LOW: begin
            if (dly_over) begin
               scl_out_in = 1'b1;
               delay_in   = long_load;
               phase_in   = i2cm_pkg::PH_BO_HIGH;
            end
         end
         i2cm_pkg::PH_BO_HIGH: begin
            if (dly_over) begin
               scl_out_in = 1'b0;
               if (held_ff == i2cm_pkg::KIND_READ) begin
                  // End of the acknowledge bit that a read sends.
                  nack_in = 1'b0;
                  done    = 1'b1;
               end else begin
                  bits_in = bits_dec;
                  if (bits_dec != 4'd0) begin
                     shift_in   = {shift_ff[6:0], 1'b0};
                     sda_out_in = shift_ff[6];
                     delay_in   = short_load;
                     phase_in   = i2cm_pkg::PH_BO_LOW;
                  end else begin
                     sda_out_in = 1'b1;
                     delay_in   = long_load;
                     phase_in   = i2cm_pkg::PH_AK_LOW;
                  end
               end
            end
         end
         i2cm_pkg::PH_AK_LOW: begin
            if (dly_over) begin
               scl_out_in = 1'b1;
               timeout_in = timeout_load;
               phase_in   = i2cm_pkg::PH_AK_WAIT;
            end
         end
         i2cm_pkg::PH_AK_WAIT: begin
            if (tick.scl_in) begin
               nack_in  = tick.sda_in;
               delay_in = long_load;
               phase_in = i2cm_pkg::PH_AK_HOLD;
            end else if (tmo_zero) begin
               nack_in  = 1'b1;
               delay_in = long_load;
               phase_in = i2cm_pkg::PH_AK_HOLD;
            end else begin
               timeout_in = timeout_tick;
            end
         end
         i2cm_pkg::PH_AK_HOLD: begin
            if (dly_over) begin
               scl_out_in = 1'b0;
               done       = 1'b1;
            end
         end
         i2cm_pkg::PH_RB_LOW: begin
            if (dly_over) begin
               scl_out_in = 1'b1;
               if (bits_ff == i2cm_pkg::BITS_PER_BYTE) begin
                  timeout_in = timeout_load;
                  phase_in   = i2cm_pkg::PH_RB_WAIT;
               end else begin
                  delay_in = long_load;
                  phase_in = i2cm_pkg::PH_RB_HIGH;
               end
            end
         end
         i2cm_pkg::PH_RB_WAIT: begin
            if (tick.scl_in || tmo_zero) begin
               delay_in = long_load;
               phase_in = i2cm_pkg::PH_RB_HIGH;
            end else begin
               timeout_in = timeout_tick;
            end
         end
         i2cm_pkg::PH_RB_HIGH: begin
            if (dly_over) begin
               shift_in   = {shift_ff[6:0], tick.sda_in};
               scl_out_in = 1'b0;
               bits_in    = bits_dec;
               delay_in   = short_load;
               phase_in   = i2cm_pkg::PH_BO_LOW;
               sda_out_in = ack_ff;
               if (bits_dec != 4'd0) begin
                  sda_out_in = 1'b1;
                  phase_in   = i2cm_pkg::PH_RB_LOW;
               end
            end
         end
         default: begin
            phase_in = i2cm_pkg::PH_IDLE;
         end
      endcase

      if (done) begin
         phase_in = i2cm_pkg::PH_IDLE;
      end
   end

   always_comb begin
      result_in.scl_release = scl_out_in;
      result_in.sda_release = sda_out_in;
      result_in.busy_res    = (phase_in != i2cm_pkg::PH_IDLE);
      result_in.done_res    = done;
      result_in.nack_status = done & nack_in;
      result_in.read_byte   = (done && held_in == i2cm_pkg::KIND_READ) ? shift_in : 8'd0;
      rsp_valid_in          = step | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         held_ff      <= i2cm_pkg::KIND_NONE;
         delay_ff     <= '0;
         timeout_ff   <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         nack_ff      <= 1'b0;
         ack_ff       <= 1'b0;
         scl_out_ff   <= 1'b1;
         sda_out_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff   <= phase_in;
            held_ff    <= held_in;
            delay_ff   <= delay_in;
            timeout_ff <= timeout_in;
            bits_ff    <= bits_in;
            shift_ff   <= shift_in;
            nack_ff    <= nack_in;
            ack_ff     <= ack_in;
            scl_out_ff <= scl_out_in;
            sda_out_ff <= sda_out_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - $bits(i2cm_pkg::result_type)){1'b0}}, result_ff};

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_byte_engine.sv
// ============================================================================
// i2c_master_byte_engine
// Tick-level I2C master that runs start, stop, byte write and byte read.
// ============================================================================
//
//   channel   direction   words                          handshake
//   req_*     in          one clock tick + command       tvalid / tready
//   rsp_*     out         line drive + status per tick   tvalid / tready
//   csr_*     in          timing registers               APB, pready high
//
// Every request word yields exactly one response word. The engine takes one
// word per cycle while the queue is not full. An accepted word is written
// into the queue, and the sequencer steps on it once the response register
// is free or being drained. That step loads the response register, which
// then offers the response. The sequencer step, a single decrement and
// compare per counter, is what sets that rate. Reset is synchronous and
// leaves the bus released with the queue empty. Either side may stall
// on its own: the four-word queue keeps taking requests while a response
// waits, and back-pressure reaches req_tready only once the queue is full.
//
`default_nettype none

module i2c_master_byte_engine #(
   parameter int unsigned TIMEOUT_WIDTH = 16,
   parameter int unsigned DELAY_WIDTH   = 10
) (
   input  wire                              clock,
   input  wire                              reset,
   // Request channel.
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // tuser: cmd[2:0]
   input  wire [2:0]                        req_tuser,
   // tdata: write_byte[7:0], send_nack[8], scl_in[9], sda_in[10], zero fill
   input  wire [15:0]                       req_tdata,
   // Response channel.
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata: scl_release[0], sda_release[1], busy_res[2], done_res[3],
   //        nack_status[4], read_byte[12:5], zero fill
   output logic [15:0]                      rsp_tdata,
   // Configuration port.
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [i2cm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [31:0]                       csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   i2cm_pkg::cfg_type  cfg;
   i2cm_pkg::tick_type push_tick;
   i2cm_pkg::tick_type head_tick;
   logic               push;
   logic               pop;
   logic               queue_empty;
   logic               queue_full;

   // Timing registers. They must be written only while the engine is idle; the block itself does not enforce it.
   i2cm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Front end: decode the command and push the tick into the queue.
   i2cm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .tick       (push_tick)
   );

   i2cm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tick (push_tick),
      .pop       (pop),
      .head_tick (head_tick),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // Back end: the phase sequencer consumes one tick per step and owns the
   // response register.
   i2cm_seq #(
      .TIMEOUT_WIDTH (TIMEOUT_WIDTH),
      .DELAY_WIDTH   (DELAY_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .tick       (head_tick),
      .tick_valid (~queue_empty),
      .tick_pop   (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> hw/rtl/i2cm_checker.sv
// ============================================================================
// i2cm_checker
// Port-level checks of the response channel of the I2C master byte engine.
// ============================================================================
`default_nettype none

module i2cm_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata
);

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   // A completing command is no longer busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done reported while still busy");

   // Status and read data are zero outside the completion word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[12:4] == 9'd0)
      else $error("status or read byte set without done");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the tick-level I2C master byte engine.
// Every request word is one bus tick that carries the sampled SCL and SDA
// levels and an optional command. The bench keeps its own copy of the phase
// sequencer and predicts the response word of every tick. A small bus model
// feeds the line levels back from the predicted drive, with an optional
// slave that stretches the clock, holds SDA low and answers with data.
// Responses are compared field by field, in order, with the predictions.
// ============================================================================

module testbench;

   // Cycles without any accepted word before the run is declared hung. The
   // longest legal quiet stretch is the deliberate response hold-off below.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_TICKS = 100;

   // ------------------------------------------------------------------------
   // Clock, reset and the ports of the block.
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = i2cm_pkg::CMD_NONE;
   logic [15:0] req_tdata = '0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [i2cm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // ------------------------------------------------------------------------
   // Shadow copy of the engine: timing registers and sequencer state.
   // ------------------------------------------------------------------------
   i2cm_pkg::cfg_type    timing = '{i2cm_pkg::SHORT_RESET, i2cm_pkg::LONG_RESET,
                                    i2cm_pkg::TIMEOUT_RESET};
   i2cm_pkg::phase_type  seq_phase = i2cm_pkg::PH_IDLE;
   logic [2:0]           held_cmd = i2cm_pkg::CMD_NONE;
   logic [i2cm_pkg::SHORT_W-1:0]   wait_left = '0;
   logic [i2cm_pkg::TIMEOUT_W-1:0] guard_left = '0;
   logic [3:0]           bits_togo = '0;
   logic [7:0]           shift_reg = '0;
   logic                 nack_seen = 1'b0;
   logic                 ack_level = 1'b0;
   logic                 drv_scl = 1'b1;
   logic                 drv_sda = 1'b1;

   // Response words predicted but not yet seen, oldest first.
   i2cm_pkg::result_type expected_bus_words[$];

   // ------------------------------------------------------------------------
   // Bus model controls. With everything clear the lines simply follow what
   // the engine drives (pull-ups, no slave).
   // ------------------------------------------------------------------------
   bit bus_scl_low = 1'b0;    // SCL held low by a slave for good
   bit bus_sda_low = 1'b0;    // SDA held low by a slave for good
   bit bus_ack_stretch = 1'b0; // SCL held low only around the ack bit
   bit bus_random = 1'b0;     // random slave: stretching, SDA holds and data
   bit bus_noise = 1'b0;      // line levels with no relation to the drive
   int stretch_left = 0;      // remaining ticks of a clock stretch
   int sda_hold_left = 0;     // remaining ticks of a slave holding SDA low

   // Idling controls; the two _pct values are percent of cycles.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   int ticks_sent = 0;
   int words_checked = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   // ------------------------------------------------------------------------
   // Block under test.
   // ------------------------------------------------------------------------
   i2c_master_byte_engine u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sequencer prediction. One call is one tick of the engine.
   // ------------------------------------------------------------------------

   // A wait counts down to one; a loaded zero therefore still lasts one tick.
   function automatic bit wait_elapsed();
      if (wait_left > 1) begin
         wait_left--;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void guard_tick();
      if (guard_left != 0) guard_left--;
   endfunction

   function automatic void drive_bit(input logic level);
      drv_scl = 1'b0;
      drv_sda = level;
      wait_left = timing.short_delay;
      seq_phase = i2cm_pkg::PH_BO_LOW;
   endfunction

   function automatic void release_for_read();
      drv_scl = 1'b0;
      drv_sda = 1'b1;
      wait_left = timing.short_delay;
      seq_phase = i2cm_pkg::PH_RB_LOW;
   endfunction

   task automatic predict_tick(input logic [2:0] cmd, input logic [7:0] wb, input logic sn,
                               input logic scl_hi, input logic sda_hi,
                               output i2cm_pkg::result_type word);
      bit done;
      done = 1'b0;
      case (seq_phase)
         i2cm_pkg::PH_IDLE: begin
            if (cmd == i2cm_pkg::CMD_START || cmd == i2cm_pkg::CMD_STOP ||
                cmd == i2cm_pkg::CMD_WRITE || cmd == i2cm_pkg::CMD_READ) begin
               held_cmd = cmd;
               nack_seen = 1'b0;
               case (cmd)
                  i2cm_pkg::CMD_START: begin
                     drv_scl = 1'b1;
                     drv_sda = 1'b1;
                     guard_left = timing.timeout_ticks;
                     seq_phase = i2cm_pkg::PH_ST_CHECK;
                  end
                  i2cm_pkg::CMD_STOP: begin
                     wait_left = timing.short_delay;
                     seq_phase = i2cm_pkg::PH_SP_A;
                  end
                  i2cm_pkg::CMD_WRITE: begin
                     shift_reg = wb;
                     bits_togo = i2cm_pkg::BITS_PER_BYTE;
                     drv_scl = 1'b0;
                     drv_sda = wb[7];
                     seq_phase = i2cm_pkg::PH_W1_RISE;
                  end
                  default: begin
                     shift_reg = '0;
                     bits_togo = i2cm_pkg::BITS_PER_BYTE;
                     ack_level = sn;
                     release_for_read();
                  end
               endcase
            end
         end
         // Start: wait for both lines high, pulsing SCL while SDA is stuck low.
         i2cm_pkg::PH_ST_CHECK: begin
            if (guard_left == 0) begin
               nack_seen = 1'b1;
               done = 1'b1;
            end else if (scl_hi && sda_hi) begin
               wait_left = timing.short_delay;
               seq_phase = i2cm_pkg::PH_ST_A;
            end else begin
               if (!sda_hi) begin
                  drv_scl = 1'b0;
                  wait_left = timing.short_delay;
                  seq_phase = i2cm_pkg::PH_ST_PLO;
               end
               guard_tick();
            end
         end
         i2cm_pkg::PH_ST_PLO: begin
            guard_tick();
            if (wait_elapsed()) begin
               drv_scl = 1'b1;
               wait_left = timing.short_delay;
               seq_phase = i2cm_pkg::PH_ST_PHI;
            end
         end
         i2cm_pkg::PH_ST_PHI: begin
            guard_tick();
            if (wait_elapsed()) seq_phase = i2cm_pkg::PH_ST_CHECK;
         end
         i2cm_pkg::PH_ST_A: begin
            if (wait_elapsed()) begin
               drv_sda = 1'b0;
               wait_left = timing.short_delay;
               seq_phase = i2cm_pkg::PH_ST_B;
            end
         end
         i2cm_pkg::PH_ST_B: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b0;
               nack_seen = 1'b0;
               done = 1'b1;
            end
         end
         // Stop: both low, release SCL, wait for it, then release SDA.
         i2cm_pkg::PH_SP_A: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b0;
               drv_sda = 1'b0;
               wait_left = timing.short_delay;
               seq_phase = i2cm_pkg::PH_SP_B;
            end
         end
         i2cm_pkg::PH_SP_B: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b1;
               guard_left = timing.timeout_ticks;
               seq_phase = i2cm_pkg::PH_SP_WAIT;
            end
         end
         i2cm_pkg::PH_SP_WAIT: begin
            if (scl_hi || guard_left == 0) begin
               wait_left = timing.short_delay;
               seq_phase = i2cm_pkg::PH_SP_C;
            end else begin
               guard_tick();
            end
         end
         i2cm_pkg::PH_SP_C: begin
            if (wait_elapsed()) begin
               drv_sda = 1'b1;
               drv_scl = 1'b1;
               wait_left = timing.long_delay;
               seq_phase = i2cm_pkg::PH_SP_D;
            end
         end
         i2cm_pkg::PH_SP_D: begin
            if (wait_elapsed()) begin
               nack_seen = 1'b0;
               done = 1'b1;
            end
         end
         // Write: the first bit waits for clock stretching.
         i2cm_pkg::PH_W1_RISE: begin
            drv_scl = 1'b1;
            guard_left = timing.timeout_ticks;
            seq_phase = i2cm_pkg::PH_W1_WAIT;
         end
         i2cm_pkg::PH_W1_WAIT: begin
            if (scl_hi) begin
               nack_seen = 1'b0;
               wait_left = timing.long_delay;
               seq_phase = i2cm_pkg::PH_W1_HOLD;
            end else if (guard_left == 0) begin
               nack_seen = 1'b1;
               wait_left = timing.long_delay;
               seq_phase = i2cm_pkg::PH_W1_HOLD;
            end else begin
               guard_tick();
            end
         end
         i2cm_pkg::PH_W1_HOLD: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b0;
               if (nack_seen) begin
                  done = 1'b1;
               end else begin
                  bits_togo = i2cm_pkg::BITS_AFTER_FIRST;
                  shift_reg = shift_reg << 1;
                  drive_bit(shift_reg[7]);
               end
            end
         end
         i2cm_pkg::PH_BO_LOW: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b1;
               wait_left = timing.long_delay;
               seq_phase = i2cm_pkg::PH_BO_HIGH;
            end
         end
         // End of a driven bit; for a read this was the ack bit.
         i2cm_pkg::PH_BO_HIGH: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b0;
               if (held_cmd == i2cm_pkg::CMD_READ) begin
                  nack_seen = 1'b0;
                  done = 1'b1;
               end else begin
                  if (bits_togo != 0) bits_togo--;
                  if (bits_togo != 0) begin
                     shift_reg = shift_reg << 1;
                     drive_bit(shift_reg[7]);
                  end else begin
                     drv_sda = 1'b1;
                     wait_left = timing.long_delay;
                     seq_phase = i2cm_pkg::PH_AK_LOW;
                  end
               end
            end
         end
         i2cm_pkg::PH_AK_LOW: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b1;
               guard_left = timing.timeout_ticks;
               seq_phase = i2cm_pkg::PH_AK_WAIT;
            end
         end
         i2cm_pkg::PH_AK_WAIT: begin
            if (scl_hi) begin
               nack_seen = sda_hi;
               wait_left = timing.long_delay;
               seq_phase = i2cm_pkg::PH_AK_HOLD;
            end else if (guard_left == 0) begin
               nack_seen = 1'b1;
               wait_left = timing.long_delay;
               seq_phase = i2cm_pkg::PH_AK_HOLD;
            end else begin
               guard_tick();
            end
         end
         i2cm_pkg::PH_AK_HOLD: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b0;
               done = 1'b1;
            end
         end
         // Read: only the first bit waits for stretching; a timeout goes on.
         i2cm_pkg::PH_RB_LOW: begin
            if (wait_elapsed()) begin
               drv_scl = 1'b1;
               if (bits_togo == i2cm_pkg::BITS_PER_BYTE) begin
                  guard_left = timing.timeout_ticks;
                  seq_phase = i2cm_pkg::PH_RB_WAIT;
               end else begin
                  wait_left = timing.long_delay;
                  seq_phase = i2cm_pkg::PH_RB_HIGH;
               end
            end
         end
         i2cm_pkg::PH_RB_WAIT: begin
            if (scl_hi || guard_left == 0) begin
               wait_left = timing.long_delay;
               seq_phase = i2cm_pkg::PH_RB_HIGH;
            end else begin
               guard_tick();
            end
         end
         i2cm_pkg::PH_RB_HIGH: begin
            if (wait_elapsed()) begin
               shift_reg = {shift_reg[6:0], sda_hi};
               drv_scl = 1'b0;
               if (bits_togo != 0) bits_togo--;
               if (bits_togo != 0) release_for_read();
               else drive_bit(ack_level);
            end
         end
         default: seq_phase = i2cm_pkg::PH_IDLE;
      endcase

      if (done) seq_phase = i2cm_pkg::PH_IDLE;

      word.scl_release = drv_scl;
      word.sda_release = drv_sda;
      word.busy_res    = (seq_phase != i2cm_pkg::PH_IDLE);
      word.done_res    = done;
      word.nack_status = done ? nack_seen : 1'b0;
      word.read_byte   = (done && held_cmd == i2cm_pkg::CMD_READ) ? shift_reg : 8'h00;
   endtask

   // ------------------------------------------------------------------------
   // Bus model: line levels seen by the engine in the next tick. Preset
   // stretches and SDA holds run out even when the random slave is off.
   // ------------------------------------------------------------------------
   task automatic next_lines(output logic scl_in, output logic sda_in);
      if (bus_noise) begin
         scl_in = 1'($urandom);
         sda_in = 1'($urandom);
         return;
      end
      scl_in = drv_scl && !bus_scl_low;
      sda_in = drv_sda && !bus_sda_low;
      if (bus_ack_stretch && (seq_phase == i2cm_pkg::PH_AK_LOW ||
                              seq_phase == i2cm_pkg::PH_AK_WAIT))
         scl_in = 1'b0;
      if (bus_random) begin
         if (stretch_left == 0 && drv_scl && $urandom_range(0, 15) == 0)
            stretch_left = $urandom_range(1, 24);
         if (sda_hold_left == 0 && $urandom_range(0, 31) == 0)
            sda_hold_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) == 0) sda_in = 1'b0;
      end
      if (stretch_left != 0) begin
         scl_in = 1'b0;
         stretch_left--;
      end
      if (sda_hold_left != 0) begin
         sda_in = 1'b0;
         sda_hold_left--;
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side. Inputs change at the falling edge; a word is accepted at
   // the rising edge where tvalid and tready are both high. tvalid is left
   // high on return so back-to-back words need no extra edge.
   // ------------------------------------------------------------------------
   task automatic send_tick(input logic [2:0] cmd, input logic [7:0] wb, input logic sn);
      logic scl_in, sda_in;
      i2cm_pkg::result_type word;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      next_lines(scl_in, sda_in);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b00000, sda_in, scl_in, sn, wb};
      do @(posedge clock); while (!req_tready);
      predict_tick(cmd, wb, sn, scl_in, sda_in, word);
      expected_bus_words.push_back(word);
      ticks_sent++;
   endtask

   // Issue a command and keep ticking until the shadow sequencer is idle.
   // With busy_noise set, some of the busy ticks carry commands that must
   // be ignored.
   task automatic run_command(input logic [2:0] cmd, input logic [7:0] wb, input logic sn,
                              input bit busy_noise);
      send_tick(cmd, wb, sn);
      while (seq_phase != i2cm_pkg::PH_IDLE) begin
         if (busy_noise && $urandom_range(0, 7) == 0)
            send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
         else
            send_tick(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Configuration writes: setup cycle, then access cycle.
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         i2cm_pkg::REG_SHORT:   timing.short_delay   = value[i2cm_pkg::SHORT_W-1:0];
         i2cm_pkg::REG_LONG:    timing.long_delay    = value[i2cm_pkg::LONG_W-1:0];
         i2cm_pkg::REG_TIMEOUT: timing.timeout_ticks = value[i2cm_pkg::TIMEOUT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Reprogram all three timing registers. The engine is brought to idle
   // and every response is collected first, so no command sees a change.
   task automatic set_timing(input logic [31:0] short_val, input logic [31:0] long_val,
                             input logic [31:0] timeout_val);
      while (seq_phase != i2cm_pkg::PH_IDLE) send_tick(i2cm_pkg::CMD_NONE, 8'h00, 1'b0);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bus_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(i2cm_pkg::REG_SHORT, short_val);
      csr_write(i2cm_pkg::REG_LONG, long_val);
      csr_write(i2cm_pkg::REG_TIMEOUT, timeout_val);
   endtask

   task automatic clear_bus();
      bus_scl_low = 1'b0;
      bus_sda_low = 1'b0;
      bus_ack_stretch = 1'b0;
      bus_random = 1'b0;
      bus_noise = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off on request.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      $display("mismatch in %0s at word %0d: expected %0h, got %0h",
               field, words_checked, want, got);
      mismatches++;
   endtask

   task automatic check_word(input logic [15:0] data);
      i2cm_pkg::result_type got, want;
      got = i2cm_pkg::result_type'(data[12:0]);
      if (expected_bus_words.size() == 0) begin
         report_mismatch("unexpected word", 16'h0000, data);
         return;
      end
      want = expected_bus_words.pop_front();
      if (got.scl_release !== want.scl_release)
         report_mismatch("scl_release", 16'(want.scl_release), 16'(got.scl_release));
      if (got.sda_release !== want.sda_release)
         report_mismatch("sda_release", 16'(want.sda_release), 16'(got.sda_release));
      if (got.busy_res !== want.busy_res)
         report_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res));
      if (got.done_res !== want.done_res)
         report_mismatch("done_res", 16'(want.done_res), 16'(got.done_res));
      if (got.nack_status !== want.nack_status)
         report_mismatch("nack_status", 16'(want.nack_status), 16'(got.nack_status));
      if (got.read_byte !== want.read_byte)
         report_mismatch("read_byte", 16'(want.read_byte), 16'(got.read_byte));
      if (data[15:13] !== 3'b000)
         report_mismatch("zero fill", 16'h0000, 16'(data[15:13]));
      words_checked++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word(rsp_tdata);
   end

   // Hang detection: any accepted word on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Reset timing values, untouched: a plain start and stop on a quiet bus.
   task automatic test_reset_timing();
      clear_bus();
      run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
      run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
   endtask

   // All registers zero: every wait lasts one tick and the first
   // stretching check is already a timeout.
   task automatic test_zero_timing();
      set_timing(32'h0, 32'h0, 32'h0);
      clear_bus();
      run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);   // start fails at once
      bus_scl_low = 1'b1;
      run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);    // stop times out, still succeeds
      run_command(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0);   // first-bit timeout, nack
      run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b0, 1'b0);    // read carries on past timeout
      clear_bus();
      bus_sda_low = 1'b1;
      run_command(i2cm_pkg::CMD_WRITE, 8'h5A, 1'b0, 1'b0);   // acked write with zero waits
   endtask

   // Byte writes: ack, nack, ack-phase timeout and first-bit timeout.
   task automatic test_write_paths();
      set_timing(32'd1, 32'd2, 32'd8);
      clear_bus();
      bus_sda_low = 1'b1;
      run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b0);
      bus_sda_low = 1'b0;
      run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0);
      bus_ack_stretch = 1'b1;
      run_command(i2cm_pkg::CMD_WRITE, 8'h81, 1'b0, 1'b0);
      bus_ack_stretch = 1'b0;
      bus_scl_low = 1'b1;
      run_command(i2cm_pkg::CMD_WRITE, 8'h7E, 1'b1, 1'b0);
      clear_bus();
   endtask

   // Byte reads: all zeros with ACK, all ones with NACK, a first-bit
   // timeout, and two with random slave data.
   task automatic test_read_paths();
      set_timing(32'd2, 32'd1, 32'd6);
      clear_bus();
      bus_sda_low = 1'b1;
      run_command(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, 1'b0);
      bus_sda_low = 1'b0;
      run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b0);
      bus_scl_low = 1'b1;
      run_command(i2cm_pkg::CMD_READ, 8'h3C, 1'b0, 1'b0);
      clear_bus();
      bus_random = 1'b1;
      run_command(i2cm_pkg::CMD_READ, 8'($urandom), 1'b0, 1'b0);
      run_command(i2cm_pkg::CMD_READ, 8'($urandom), 1'b1, 1'b0);
      clear_bus();
   endtask

   // Start on a stuck bus: recovery that succeeds, recovery that runs out
   // of time, and SCL held low so no pulse is ever issued.
   task automatic test_start_recovery();
      set_timing(32'd2, 32'd3, 32'd60);
      clear_bus();
      sda_hold_left = 25;
      run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
      bus_sda_low = 1'b1;
      run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
      bus_sda_low = 1'b0;
      bus_scl_low = 1'b1;
      run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
      clear_bus();
      run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
   endtask

   // Unknown codes while idle and every command while busy are ignored.
   task automatic test_ignored_commands();
      logic [2:0] code;
      clear_bus();
      for (int c = i2cm_pkg::CMD_READ + 1; c < 8; c++) begin
         code = c[2:0];
         send_tick(code, 8'hFF, 1'b1);
      end
      send_tick(i2cm_pkg::CMD_NONE, 8'hFF, 1'b1);
      bus_sda_low = 1'b1;
      send_tick(i2cm_pkg::CMD_WRITE, 8'hC3, 1'b0);
      send_tick(i2cm_pkg::CMD_START, 8'h00, 1'b0);
      send_tick(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
      send_tick(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
      send_tick(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0);
      run_command(i2cm_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1);
      clear_bus();
   endtask

   // Writes with the upper bits all set: the block keeps only the register
   // widths, so the delays come out short and the timeout at its largest.
   task automatic test_max_timing();
      set_timing(32'hFFFF_FC02, 32'hFFFF_FC03, 32'hFFFF_FFFF);
      clear_bus();
      run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b0);
      bus_sda_low = 1'b1;
      run_command(i2cm_pkg::CMD_WRITE, 8'h96, 1'b0, 1'b0);
      clear_bus();
   endtask

   // The response side stops for a long stretch while ticks keep coming,
   // so the internal queue fills and req_tready must fall.
   task automatic test_backpressure();
      set_timing(32'd1, 32'd1, 32'd20);
      clear_bus();
      bus_random = 1'b1;
      hold_request = HOLD_OFF_CYCLES;
      repeat (6) run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'b0, 1'b1);
      clear_bus();
   endtask

   task automatic random_timing();
      logic [31:0] short_val, long_val, timeout_val;
      // Upper bits beyond each register's width are random and dropped.
      short_val = ($urandom & 32'hFFFF_FC00) | $urandom_range(0, 2);
      long_val  = ($urandom & 32'hFFFF_FC00) | $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) short_val[9:0] = 10'($urandom_range(3, 12));
      case ($urandom_range(0, 5))
         0: timeout_val = 32'h0;
         1: timeout_val = $urandom;
         default: timeout_val = ($urandom & 32'hFFFF_0000) | $urandom_range(1, 30);
      endcase
      set_timing(short_val, long_val, timeout_val);
   endtask

   // A bus transaction: start, some writes, some reads (the last one
   // NACKed), stop. One in sixteen loses its start, one in sixteen its stop.
   task automatic run_transaction();
      int writes, reads;
      writes = $urandom_range(1, 3);
      reads = $urandom_range(0, 2);
      bus_random = 1'b1;
      bus_noise = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 5) == 0) sda_hold_left = $urandom_range(1, 40);
      if ($urandom_range(0, 15) != 0)
         run_command(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), 1'b1);
      repeat (writes) run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), 1'b1);
      for (int r = 0; r < reads; r++)
         run_command(i2cm_pkg::CMD_READ, 8'($urandom),
                     (r == reads - 1) ? 1'b1 : 1'($urandom), 1'b1);
      repeat ($urandom_range(0, 2))
         send_tick(3'($urandom_range(i2cm_pkg::CMD_READ + 1, 7)), 8'($urandom),
                   1'($urandom));
      if ($urandom_range(0, 15) != 0)
         run_command(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 1'b1);
      clear_bus();
   endtask

   // Random traffic in four idling phases: none, sender idle, receiver
   // stalling, both.
   task automatic test_random_traffic();
      int phase_start;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         phase_start = ticks_sent;
         random_timing();
         while (ticks_sent - phase_start < PHASE_TICKS) begin
            if ($urandom_range(0, 1) == 0) random_timing();
            run_transaction();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Run order.
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_timing();
      test_zero_timing();
      test_write_paths();
      test_read_paths();
      test_start_recovery();
      test_ignored_commands();
      test_max_timing();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      while (expected_bus_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
